@@ sv/sbcd_pkg.sv @@
// Package for the start-byte checksum deframer.
// Shared constants and the result record; used by every module of the block.
`timescale 1ns / 1ps

package sbcd_pkg;

	localparam int BYTE_W     = 8;
	localparam int VALUE_W    = 32;
	localparam int BODY_BYTES = 12;
	localparam int BODY_W     = BODY_BYTES * BYTE_W;
	localparam int POS_W      = 4;

	// Reset value of the start code register
	localparam logic [BYTE_W-1:0] START_CODE_RESET = 8'h24;

	// Frame position of the checksum byte (start byte is position 0)
	localparam logic [POS_W-1:0] CHECK_POS = POS_W'(BODY_BYTES + 1);

	// One completed frame
	typedef struct packed {
		logic [VALUE_W-1:0] first_value;
		logic [VALUE_W-1:0] second_value;
		logic [VALUE_W-1:0] third_value;
		logic [BYTE_W-1:0]  sent_checksum;
		logic [BYTE_W-1:0]  computed_sum;
		logic               check_passed;
	} result_t;

endpackage

@@ sv/sbcd_assembler.sv @@
// Frame assembler: input register, start-byte hunt, body store and running sum.
// Depends on sbcd_pkg.
`timescale 1ns / 1ps

module sbcd_assembler (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sbcd_pkg::BYTE_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [sbcd_pkg::BYTE_W-1:0] in_byte,
	output logic                       res_valid,
	input  logic                       res_ready,
	output sbcd_pkg::result_t          res_data
);
	import sbcd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [BYTE_W-1:0] start_code_q;
	logic              in_frame_q;
	logic [POS_W-1:0]  pos_q;
	logic [BODY_W-1:0] body_q;
	logic [BYTE_W-1:0] sum_q;
	logic              is_check;
	logic              s1_go;
	logic              consume;

	// Checksum byte needs room downstream; every other byte advances freely
	assign is_check  = in_frame_q && (pos_q == CHECK_POS);
	assign s1_go     = !is_check || res_ready;
	assign consume   = valid_s1 && s1_go;
	assign in_ready  = !valid_s1 || s1_go;
	assign res_valid = valid_s1 && is_check;

	// Build the result from the stored body and the closing byte
	always_comb begin
		res_data.first_value   = body_q[0*VALUE_W +: VALUE_W];
		res_data.second_value  = body_q[1*VALUE_W +: VALUE_W];
		res_data.third_value   = body_q[2*VALUE_W +: VALUE_W];
		res_data.sent_checksum = byte_s1;
		res_data.computed_sum  = sum_q;
		res_data.check_passed  = (sum_q == byte_s1);
	end

	// Start code register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= START_CODE_RESET;
		end else if (cfg_we) begin
			start_code_q <= cfg_wdata;
		end
	end

	// Input register: hold the byte until the frame logic takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Frame state: hunt, count body bytes, close on the checksum byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			sum_q      <= '0;
		end else if (consume) begin
			if (!in_frame_q) begin
				if (byte_s1 == start_code_q) begin
					in_frame_q <= 1'b1;
					pos_q      <= POS_W'(1);
					sum_q      <= '0;
				end
			end else if (is_check) begin
				in_frame_q <= 1'b0;
				pos_q      <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				sum_q <= sum_q + byte_s1;
			end
		end
	end

	// Body store: drop each body byte into its lane
	always_ff @(posedge clk) begin
		for (int i = 0; i < BODY_BYTES; i++) begin
			if (consume && in_frame_q && (pos_q == POS_W'(i + 1))) begin
				body_q[i*BYTE_W +: BYTE_W] <= byte_s1;
			end
		end
	end

`ifndef SYNTH
	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (pos_q >= POS_W'(1)) && (pos_q <= CHECK_POS))
		else $error("frame position out of range");

	a_pos_hunting: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (pos_q == '0))
		else $error("position not cleared while hunting");

	a_frame_open: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && !in_frame_q && (byte_s1 == start_code_q))
			|=> in_frame_q && (pos_q == POS_W'(1)) && (sum_q == '0))
		else $error("frame did not open cleanly on start byte");

	a_frame_close: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && is_check) |=> !in_frame_q)
		else $error("frame did not close after checksum byte");
`endif

endmodule

@@ sv/sbcd_out_reg.sv @@
// Output register for completed frames, with stream handshake.
// Depends on sbcd_pkg.
`timescale 1ns / 1ps

module sbcd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sbcd_pkg::result_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sbcd_pkg::result_t out_data
);
	import sbcd_pkg::*;

	logic    valid_q;
	result_t data_q;

	// Take a new result when empty or when the current one leaves
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end

endmodule

@@ sv/start_byte_checksum_deframer_top.sv @@
// Start-byte deframer with additive checksum: top level.
// Instantiates sbcd_assembler and sbcd_out_reg; depends on sbcd_pkg.
//
// Usage:
//   s_* carries one received byte per transaction. While hunting, bytes are
//   dropped until one equals the start code (cfg_wdata written with cfg_we,
//   0x24 after reset). The next 12 bytes are the body, the 13th the checksum;
//   a start code inside a frame is plain data.
//   m_* carries one transaction per frame: three 32-bit little-endian values,
//   the sent checksum and the computed sum in m_tdata, the pass flag in
//   m_tuser. Values are delivered even when the check fails.
// Timing:
//   One byte per cycle sustained while s_tready is high. A result reaches m_*
//   through the input register, where the checksum byte lands, and then the
//   output register, which takes the result once it has room.
// Reset:
//   arst_n clears both stage valids and returns the block to hunting.
// Stall:
//   With a result held in the output register and m_tready low, body bytes
//   keep flowing; only the next checksum byte waits in the input register,
//   and s_tready drops until the output register frees.
`timescale 1ns / 1ps

module start_byte_checksum_deframer_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] rx_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] first_value, [63:32] second_value, [95:64] third_value,
	// [103:96] sent_checksum, [111:104] computed_sum
	output logic [111:0] m_tdata,
	output logic         m_tuser    // [0] check_passed
);
	import sbcd_pkg::*;

	logic    res_valid;
	logic    res_ready;
	result_t res_data;
	result_t out_data;

	// Frame assembly
	sbcd_assembler u_assembler (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	// Result register
	sbcd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_data   (res_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

	// Pack the result onto the stream fields
	assign m_tdata = {out_data.computed_sum, out_data.sent_checksum, out_data.third_value,
			out_data.second_value, out_data.first_value};
	assign m_tuser = out_data.check_passed;

endmodule

@@ verif/sbcd_frame_checker.sv @@
// Scoreboard for the start-byte checksum deframer: mirrors the frame state from the
// accepted byte and register-write transactions and compares every result transaction.
// Depends on sbcd_pkg for widths, the reset start code and the result record.
`timescale 1ns / 1ps

module sbcd_frame_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [111:0] m_tdata,
	input  logic         m_tuser,
	output int           fail_count,
	output int           pending,
	output int           frames_checked,
	output int           bad_sum_frames
);
	import sbcd_pkg::*;

	// Mirror of the deframer state
	logic [BYTE_W-1:0] frame_code;
	logic              collecting;
	logic [POS_W-1:0]  frame_pos;
	logic [BODY_W-1:0] body_bytes;
	logic [BYTE_W-1:0] body_sum;

	// Frames predicted but not yet delivered, oldest first
	result_t expected_frames[$];

	always @(posedge clk or negedge arst_n) begin : track_and_check
		logic [BYTE_W-1:0] rx;
		result_t           want;
		result_t           got;

		if (!arst_n) begin
			frame_code = START_CODE_RESET;
			collecting = 1'b0;
			frame_pos  = '0;
			body_bytes = '0;
			body_sum   = '0;
			expected_frames.delete();
			fail_count     <= 0;
			pending        <= 0;
			frames_checked <= 0;
			bad_sum_frames <= 0;
		end else begin
			// Take a register write
			if (cfg_we)
				frame_code = cfg_wdata;

			// Advance the frame state on an accepted byte
			if (s_tvalid && s_tready) begin
				rx = s_tdata;
				if (!collecting) begin
					if (rx == frame_code) begin
						collecting = 1'b1;
						frame_pos  = POS_W'(1);
						body_sum   = '0;
					end
				end else if (frame_pos != CHECK_POS) begin
					body_bytes[(frame_pos - 1) * BYTE_W +: BYTE_W] = rx;
					body_sum  = body_sum + rx;
					frame_pos = frame_pos + 1'b1;
				end else begin
					want.first_value   = body_bytes[0 +: VALUE_W];
					want.second_value  = body_bytes[VALUE_W +: VALUE_W];
					want.third_value   = body_bytes[2 * VALUE_W +: VALUE_W];
					want.sent_checksum = rx;
					want.computed_sum  = body_sum;
					want.check_passed  = (body_sum == rx);
					expected_frames.push_back(want);
					collecting = 1'b0;
					frame_pos  = '0;
				end
			end

			// Compare a delivered frame against the oldest prediction
			if (m_tvalid && m_tready) begin
				got.first_value   = m_tdata[31:0];
				got.second_value  = m_tdata[63:32];
				got.third_value   = m_tdata[95:64];
				got.sent_checksum = m_tdata[103:96];
				got.computed_sum  = m_tdata[111:104];
				got.check_passed  = m_tuser;
				if (expected_frames.size() == 0) begin
					$error("unexpected frame result: values %h %h %h",
						got.first_value, got.second_value, got.third_value);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_frames.pop_front();
					frames_checked <= frames_checked + 1;
					if (!want.check_passed)
						bad_sum_frames <= bad_sum_frames + 1;
					if (got != want) begin
						fail_count <= fail_count + 1;
						if (got.first_value != want.first_value)
							$error("first_value mismatch: expected %h, got %h",
								want.first_value, got.first_value);
						if (got.second_value != want.second_value)
							$error("second_value mismatch: expected %h, got %h",
								want.second_value, got.second_value);
						if (got.third_value != want.third_value)
							$error("third_value mismatch: expected %h, got %h",
								want.third_value, got.third_value);
						if (got.sent_checksum != want.sent_checksum)
							$error("sent_checksum mismatch: expected %h, got %h",
								want.sent_checksum, got.sent_checksum);
						if (got.computed_sum != want.computed_sum)
							$error("computed_sum mismatch: expected %h, got %h",
								want.computed_sum, got.computed_sum);
						if (got.check_passed != want.check_passed)
							$error("check_passed mismatch: expected %b, got %b",
								want.check_passed, got.check_passed);
					end
				end
			end

			pending <= expected_frames.size();
		end
	end

endmodule

@@ verif/tb_start_byte_checksum_deframer_top.sv @@
// Testbench top for the start-byte checksum deframer: clock, reset, byte stream,
// start code writes and verdict. Depends on sbcd_pkg and sbcd_frame_checker.
`timescale 1ns / 1ps

module tb_start_byte_checksum_deframer_top;
	import sbcd_pkg::*;

	localparam int SEGMENTS     = 6;
	localparam int SEG_BYTES    = 150;
	localparam int DRAIN_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 300000;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         cfg_we    = 1'b0;
	logic [7:0]   cfg_wdata = '0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata   = '0;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [111:0] m_tdata;
	logic         m_tuser;

	int fail_count;
	int pending;
	int frames_checked;
	int bad_sum_frames;

	int send_gap_pct   = 20;
	int ready_stall_pct = 47;
	int bytes_sent     = 0;
	int code_writes    = 0;
	int cycle_count    = 0;

	start_byte_checksum_deframer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	sbcd_frame_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.fail_count     (fail_count),
		.pending        (pending),
		.frames_checked (frames_checked),
		.bad_sum_frames (bad_sum_frames)
	);

	always #4 clk = ~clk;

	// Stall the result channel at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
	end

	// Hard stop on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offer one byte, idling first at random, and hold it until the transaction
	task automatic push_byte(input logic [7:0] value);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do
			@(posedge clk);
		while (!s_tready);
		bytes_sent++;
	endtask

	// Send start code, twelve body bytes and a checksum, corrupted on request
	task automatic send_frame(input logic [7:0] code, input logic [7:0] body [12],
			input bit corrupt);
		logic [7:0] sum;
		sum = '0;
		push_byte(code);
		for (int i = 0; i < 12; i++) begin
			push_byte(body[i]);
			sum += body[i];
		end
		push_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
	endtask

	// Let every frame drain, then write the start code while the block is idle
	task automatic drain_and_set_code(input logic [7:0] code);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_we <= 1'b0;
		code_writes++;
	endtask

	initial begin : stimulus
		logic [7:0] body [12];
		logic [7:0] seg_code [SEGMENTS];
		logic [7:0] b;
		int         seg_goal;
		int         pick;

		seg_code = '{8'h00, 8'hff, 8'h24, 8'h00, 8'h7e, 8'h00};
		seg_code[3] = 8'($urandom_range(0, 255));
		seg_code[5] = 8'($urandom_range(0, 255));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme noise bytes while hunting, then a clean frame with
		// extreme body bytes and the start code repeated inside the body
		push_byte(8'h00);
		push_byte(8'hff);
		body = '{8'hff, 8'h00, 8'h24, 8'hff, 8'h80, 8'h01,
			8'h7f, 8'hfe, 8'h24, 8'hff, 8'h00, 8'h55};
		send_frame(START_CODE_RESET, body, 1'b0);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			// Receiver-heavy idling, then sender-heavy, then none
			case (seg / 2)
				0: begin
					send_gap_pct    = 20;
					ready_stall_pct = 47;
				end
				1: begin
					send_gap_pct    = 47;
					ready_stall_pct = 20;
				end
				default: begin
					send_gap_pct    = 0;
					ready_stall_pct = 0;
				end
			endcase
			drain_and_set_code(seg_code[seg]);

			seg_goal = bytes_sent + SEG_BYTES;
			while (bytes_sent < seg_goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					// Frame behind up to three noise bytes, its checksum corrupted one time in four
					repeat ($urandom_range(0, 3))
						push_byte(8'($urandom_range(0, 255)));
					foreach (body[i]) begin
						case ($urandom_range(0, 9))
							0: b = seg_code[seg];
							1: b = 8'h00;
							2: b = 8'hff;
							default: b = 8'($urandom_range(0, 255));
						endcase
						body[i] = b;
					end
					send_frame(seg_code[seg], body, $urandom_range(0, 3) == 0);
				end else begin
					// Raw burst, possibly opening a frame at an arbitrary spot
					repeat ($urandom_range(1, 20)) begin
						if ($urandom_range(0, 7) == 0)
							push_byte(seg_code[seg]);
						else
							push_byte(8'($urandom_range(0, 255)));
					end
				end
			end
		end

		drain_and_set_code(START_CODE_RESET);

		$display("Covered %0d bytes, %0d frames checked (%0d with a bad checksum),",
			bytes_sent, frames_checked, bad_sum_frames);
		$display("across %0d start code writes and three idling mixes.", code_writes);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
